@@ rtl/core/apsp_pkg.sv @@
// Shared types and constants for the all-pairs shortest path engine.
// No dependencies; every other file refers to this package by scoped name.
package apsp_pkg;

  localparam int DistW   = 38;
  localparam int WeightW = 32;
  localparam int NodeW   = 6;
  localparam int OpW     = 3;
  localparam int CfgW    = 7;

  localparam logic [DistW-1:0] DistInf     = '1;
  localparam logic [CfgW-1:0]  NumNodesRst = 7'd64;

  typedef logic [DistW-1:0] dist_t;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OPS,
    ST_RD_CUR,
    ST_UPDATE,
    ST_QUERY,
    ST_QOUT
  } state_e;

  typedef struct packed {
    dist_t sum;
    dist_t low;
  } alu_res_t;

endpackage

@@ rtl/core/apsp_alu.sv @@
// Shared saturating adder with min-compare for matrix relaxation.
// Depends on apsp_pkg.
module apsp_alu (
  input  apsp_pkg::dist_t    op_a_i,
  input  apsp_pkg::dist_t    op_b_i,
  input  apsp_pkg::dist_t    cur_i,
  output apsp_pkg::alu_res_t res_o
);

  logic [apsp_pkg::DistW:0] raw;
  logic                     sat;

  assign raw = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign sat = (op_a_i == apsp_pkg::DistInf) || (op_b_i == apsp_pkg::DistInf) ||
               raw[apsp_pkg::DistW] || (&raw[apsp_pkg::DistW-1:0]);

  always_comb begin
    res_o.sum = sat ? apsp_pkg::DistInf : raw[apsp_pkg::DistW-1:0];
    res_o.low = (res_o.sum < cur_i) ? res_o.sum : cur_i;
  end

endmodule

@@ rtl/core/apsp_mem.sv @@
// Distance matrix RAM: one write port, two registered read ports.
// Depends on apsp_pkg.
module apsp_mem #(
  parameter int AW = 12
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  apsp_pkg::dist_t       wdata_i,
  input  logic [AW-1:0]         raddr0_i,
  input  logic [AW-1:0]         raddr1_i,
  output apsp_pkg::dist_t       rdata0_o,
  output apsp_pkg::dist_t       rdata1_o
);

  localparam int Depth = 1 << AW;

  apsp_pkg::dist_t mem_q [Depth];
  apsp_pkg::dist_t rdata0_q;
  apsp_pkg::dist_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ rtl/core/apsp_ctrl.sv @@
// Sequencer: request decode, loop counters, relax steps, clearing sweep, query result.
// Depends on apsp_pkg; drives apsp_mem and apsp_alu from the top level.
module apsp_ctrl #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [apsp_pkg::OpW-1:0]              operation_i,
  input  logic [apsp_pkg::NodeW-1:0]            node_a_i,
  input  logic [apsp_pkg::NodeW-1:0]            node_b_i,
  input  logic [apsp_pkg::WeightW-1:0]          weight_i,
  input  logic [apsp_pkg::CfgW-1:0]             num_nodes_i,
  output logic                                  mem_we_o,
  output logic [2*$clog2(MAX_NODES)-1:0]        mem_waddr_o,
  output apsp_pkg::dist_t                       mem_wdata_o,
  output logic [2*$clog2(MAX_NODES)-1:0]        mem_raddr0_o,
  output logic [2*$clog2(MAX_NODES)-1:0]        mem_raddr1_o,
  input  apsp_pkg::dist_t                       mem_rdata0_i,
  input  apsp_pkg::dist_t                       mem_rdata1_i,
  output apsp_pkg::dist_t                       alu_a_o,
  output apsp_pkg::dist_t                       alu_b_o,
  output apsp_pkg::dist_t                       alu_cur_o,
  input  apsp_pkg::alu_res_t                    alu_res_i,
  output logic                                  result_valid_o,
  output apsp_pkg::dist_t                       distance_o,
  output logic                                  unreachable_o
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int AW   = 2 * NW;
  localparam int CmpW = ($clog2(MAX_NODES + 1) > apsp_pkg::CfgW) ?
                        $clog2(MAX_NODES + 1) : apsp_pkg::CfgW;
  localparam logic [63:0] WMaskW = (64'd1 << WEIGHT_BITS) - 64'd1;
  localparam logic [apsp_pkg::WeightW-1:0] WMask = WMaskW[apsp_pkg::WeightW-1:0];

  apsp_pkg::state_e state_q, state_d;
  apsp_pkg::op_e    op_q, op_d;
  logic [NW-1:0]    a_q, a_d, b_q, b_d;
  logic [NW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic             half_q, half_d;
  logic             rng_q, rng_d;
  apsp_pkg::dist_t  w_q, w_d, s1_q, s1_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             res_valid_q, res_valid_d;
  apsp_pkg::dist_t  dist_q, dist_d;
  logic             unr_q, unr_d;

  logic [CmpW-1:0]  n_act, n_last;
  logic             in_range, i_last, j_last, k_last, done;
  logic [AW-1:0]    tgt;

  assign n_act = (CmpW'(num_nodes_i) > CmpW'(MAX_NODES)) ? CmpW'(MAX_NODES) :
                 CmpW'(num_nodes_i);
  assign n_last   = n_act - CmpW'(1);
  assign in_range = (CmpW'(node_a_i) < n_act) && (CmpW'(node_b_i) < n_act);
  assign i_last   = (CmpW'(i_q) == n_last);
  assign j_last   = (CmpW'(j_q) == n_last);
  assign k_last   = (CmpW'(k_q) == n_last);
  assign done     = j_last && i_last && ((op_q == apsp_pkg::OP_INSERT) || k_last);
  assign busy     = (state_q != apsp_pkg::ST_IDLE);

  always_comb begin
    if (op_q == apsp_pkg::OP_LOAD) begin
      tgt = half_q ? {b_q, a_q} : {a_q, b_q};
    end else begin
      tgt = {i_q, j_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apsp_pkg::ST_CLEAR;
      op_q        <= apsp_pkg::OP_CLEAR;
      clr_q       <= '0;
      half_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      clr_q       <= clr_d;
      half_q      <= half_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    rng_q  <= rng_d;
    w_q    <= w_d;
    s1_q   <= s1_d;
    dist_q <= dist_d;
    unr_q  <= unr_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    half_d       = half_q;
    rng_d        = rng_q;
    w_d          = w_q;
    s1_d         = s1_q;
    clr_d        = clr_q;
    res_valid_d  = 1'b0;
    dist_d       = dist_q;
    unr_d        = unr_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = tgt;
    mem_wdata_o  = alu_res_i.low;
    mem_raddr0_o = tgt;
    mem_raddr1_o = tgt;
    alu_a_o      = mem_rdata0_i;
    alu_b_o      = mem_rdata1_i;
    alu_cur_o    = apsp_pkg::DistInf;

    case (state_q)
      apsp_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = (clr_q[AW-1:NW] == clr_q[NW-1:0]) ? '0 : apsp_pkg::DistInf;
        clr_d       = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = apsp_pkg::ST_IDLE;
        end
      end
      apsp_pkg::ST_IDLE: begin
        if (start) begin
          op_d   = apsp_pkg::op_e'(operation_i);
          a_d    = NW'(node_a_i);
          b_d    = NW'(node_b_i);
          w_d    = apsp_pkg::DistW'(weight_i & WMask);
          rng_d  = in_range;
          half_d = 1'b0;
          i_d    = '0;
          j_d    = '0;
          k_d    = '0;
          clr_d  = '0;
          case (apsp_pkg::op_e'(operation_i))
            apsp_pkg::OP_LOAD, apsp_pkg::OP_INSERT: begin
              if (in_range) begin
                state_d = apsp_pkg::ST_RD_OPS;
              end
            end
            apsp_pkg::OP_CLOSE: begin
              if (n_act != '0) begin
                state_d = apsp_pkg::ST_RD_OPS;
              end
            end
            apsp_pkg::OP_QUERY: state_d = apsp_pkg::ST_QUERY;
            apsp_pkg::OP_CLEAR: state_d = apsp_pkg::ST_CLEAR;
            default: state_d = apsp_pkg::ST_IDLE;
          endcase
        end
      end
      apsp_pkg::ST_RD_OPS: begin
        case (op_q)
          apsp_pkg::OP_CLOSE: begin
            mem_raddr0_o = {i_q, k_q};
            mem_raddr1_o = {k_q, j_q};
          end
          apsp_pkg::OP_INSERT: begin
            mem_raddr0_o = half_q ? {i_q, b_q} : {i_q, a_q};
            mem_raddr1_o = half_q ? {a_q, j_q} : {b_q, j_q};
          end
          default: ;
        endcase
        state_d = apsp_pkg::ST_RD_CUR;
      end
      apsp_pkg::ST_RD_CUR: begin
        s1_d    = (op_q == apsp_pkg::OP_LOAD) ? '0 : alu_res_i.sum;
        state_d = apsp_pkg::ST_UPDATE;
      end
      apsp_pkg::ST_UPDATE: begin
        alu_a_o   = s1_q;
        alu_b_o   = (op_q == apsp_pkg::OP_CLOSE) ? '0 : w_q;
        alu_cur_o = mem_rdata0_i;
        mem_we_o  = 1'b1;
        if ((op_q != apsp_pkg::OP_CLOSE) && !half_q) begin
          half_d  = 1'b1;
          state_d = apsp_pkg::ST_RD_OPS;
        end else if (op_q == apsp_pkg::OP_LOAD) begin
          state_d = apsp_pkg::ST_IDLE;
        end else begin
          half_d = 1'b0;
          j_d    = j_last ? '0 : j_q + NW'(1);
          if (j_last) begin
            i_d = i_last ? '0 : i_q + NW'(1);
          end
          if (j_last && i_last && !k_last) begin
            k_d = k_q + NW'(1);
          end
          state_d = done ? apsp_pkg::ST_IDLE : apsp_pkg::ST_RD_OPS;
        end
      end
      apsp_pkg::ST_QUERY: begin
        mem_raddr0_o = {a_q, b_q};
        state_d      = apsp_pkg::ST_QOUT;
      end
      apsp_pkg::ST_QOUT: begin
        res_valid_d = 1'b1;
        unr_d       = !rng_q || (mem_rdata0_i == apsp_pkg::DistInf);
        dist_d      = (!rng_q || (mem_rdata0_i == apsp_pkg::DistInf)) ? '0 : mem_rdata0_i;
        state_d     = apsp_pkg::ST_IDLE;
      end
      default: state_d = apsp_pkg::ST_IDLE;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign distance_o     = dist_q;
  assign unreachable_o  = unr_q;

`ifndef SYNTH
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == apsp_pkg::OP_QUERY)) |-> ##3 res_valid_q)
    else $error("query request gave no result strobe");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == apsp_pkg::ST_QOUT))
    else $error("result strobe outside a query");

  a_update_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apsp_pkg::ST_UPDATE) |-> (mem_wdata_o <= mem_rdata0_i))
    else $error("relax step raised a distance");

  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == apsp_pkg::ST_IDLE) && ($past(state_q) == apsp_pkg::ST_CLEAR))
    |-> $past(&clr_q))
    else $error("clearing sweep ended early");
`endif

endmodule

@@ rtl/core/all_pairs_shortest_path_engine.sv @@
// Top level: config register, sequencer, shared saturating adder and matrix RAM.
// Query: result strobe registered after ST_QUERY and ST_QOUT; busy for the whole request.
// Load edge: relaxes (a,b), then (b,a). Insert edge: two relax steps per entry. Close:
// one relax step per (i,j,k), each a read, add, write loop of the one adder on the
// dual-read matrix RAM. Clear: one entry per cycle, 4**ceil(log2(MAX_NODES)) entries.
// Async reset runs the same clearing pass with busy high; results cannot be stalled.
module all_pairs_shortest_path_engine #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [apsp_pkg::OpW-1:0]      operation_i,
  input  logic [apsp_pkg::NodeW-1:0]    node_a_i,
  input  logic [apsp_pkg::NodeW-1:0]    node_b_i,
  input  logic [apsp_pkg::WeightW-1:0]  weight_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apsp_pkg::CfgW-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [apsp_pkg::DistW-1:0]    distance_o,
  output logic                          unreachable_o
);

  localparam int AW = 2 * $clog2(MAX_NODES);

  logic [apsp_pkg::CfgW-1:0] num_nodes_q, num_nodes_d;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr0, mem_raddr1;
  apsp_pkg::dist_t           mem_wdata, mem_rdata0, mem_rdata1;
  apsp_pkg::dist_t           alu_a, alu_b, alu_cur;
  apsp_pkg::alu_res_t        alu_res;

  assign cfg_ready_o = !busy;
  assign num_nodes_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : num_nodes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= apsp_pkg::NumNodesRst;
    end else begin
      num_nodes_q <= num_nodes_d;
    end
  end

  apsp_ctrl #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .weight_i       (weight_i),
    .num_nodes_i    (num_nodes_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr0_o   (mem_raddr0),
    .mem_raddr1_o   (mem_raddr1),
    .mem_rdata0_i   (mem_rdata0),
    .mem_rdata1_i   (mem_rdata1),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_cur_o      (alu_cur),
    .alu_res_i      (alu_res),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o),
    .unreachable_o  (unreachable_o)
  );

  apsp_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .cur_i  (alu_cur),
    .res_o  (alu_res)
  );

  apsp_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (mem_raddr0),
    .raddr1_i (mem_raddr1),
    .rdata0_o (mem_rdata0),
    .rdata1_o (mem_rdata1)
  );

endmodule
